FILE: sv/bdlp_pkg.sv
// Shared types and constants for the button debounce / long-press block.
// Used by bdlp_lane, bdlp_merge and button_debounce_long_press_core.
package bdlp_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 3;
   localparam int HOLD_W              = 16;
   localparam int HIST_W              = 3;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 16;
   localparam int NUM_FLAGS           = 4;

   localparam logic [HOLD_W-1:0] HOLD_MAX          = {HOLD_W{1'b1}};
   localparam logic [HOLD_W-1:0] SHORT_HOLD_RESET  = 16'd100;
   localparam logic [HOLD_W-1:0] LONG_HOLD_RESET   = 16'd300;
   localparam logic [HIST_W-1:0] HIST_ALL_LOW      = '0;
   localparam logic [HIST_W-1:0] HIST_ALL_HIGH     = '1;
   // history resets to the released level under the reset pressed level (low)
   localparam logic [HIST_W-1:0] HIST_RESET        = HIST_ALL_HIGH;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_HOLD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_HOLD     = 2'd2;

   typedef enum logic [5:0] {
      ST_INIT         = 6'b000001,
      ST_STABLE       = 6'b000010,
      ST_PRESSED      = 6'b000100,
      ST_BOUNCE_REL   = 6'b001000,
      ST_BOUNCE_PRESS = 6'b010000,
      ST_RELEASED     = 6'b100000
   } state_type;

   typedef struct packed {
      logic pressed;
      logic short_hold;
      logic long_hold;
      logic released;
   } flags_type;

   typedef struct packed {
      logic              pressed_level;
      logic [HOLD_W-1:0] short_hold_ticks;
      logic [HOLD_W-1:0] long_hold_ticks;
   } cfg_type;

endpackage

FILE: sv/bdlp_lane.sv
// One button lane: sample history, debounce state machine and hold counter.
// Depends on bdlp_pkg.
module bdlp_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                pin_level,
   input  bdlp_pkg::cfg_type   cfg,
   output bdlp_pkg::flags_type flags_next
);
   import bdlp_pkg::*;

   logic [HIST_W-1:0] history_ff, history_in;
   state_type         state_ff, state_in;
   logic              settled_ff, settled_in;
   logic [HOLD_W-1:0] count_ff, count_in, count_adv;
   flags_type         flags_ff, flags_in;
   logic              agree;

   always_comb begin
      history_in = {history_ff[HIST_W-2:0], pin_level};
      agree      = (history_in == HIST_ALL_LOW) || (history_in == HIST_ALL_HIGH);
      count_adv  = (agree && (count_ff != HOLD_MAX)) ? count_ff + HOLD_W'(1) : count_ff;
      state_in   = state_ff;
      settled_in = settled_ff;
      count_in   = count_ff;
      flags_in   = flags_ff;
      unique case (state_ff)
         ST_INIT, ST_BOUNCE_REL: begin
            if (agree) begin
               settled_in = history_in[0];
               state_in   = ST_STABLE;
            end
         end
         ST_STABLE: begin
            if (settled_ff == cfg.pressed_level) state_in = ST_PRESSED;
            if (!agree) state_in = ST_BOUNCE_REL;
         end
         ST_PRESSED: begin
            flags_in.pressed  = 1'b1;
            flags_in.released = 1'b0;
            count_in          = count_adv;
            if (count_adv >= cfg.short_hold_ticks) flags_in.short_hold = 1'b1;
            if (count_adv >= cfg.long_hold_ticks) flags_in.long_hold = 1'b1;
            if (!agree) begin
               state_in = ST_BOUNCE_PRESS;
               count_in = '0;
            end
         end
         ST_BOUNCE_PRESS: begin
            if (agree) begin
               settled_in = history_in[0];
               state_in   = ST_RELEASED;
            end
         end
         ST_RELEASED: begin
            flags_in = '{pressed: 1'b0, short_hold: 1'b0, long_hold: 1'b0, released: 1'b1};
            if (!agree) state_in = ST_BOUNCE_REL;
         end
         default: begin
         end
      endcase
   end

   assign flags_next = flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= HIST_RESET;
         state_ff   <= ST_INIT;
         settled_ff <= 1'b0;
         count_ff   <= '0;
         flags_ff   <= '0;
      end else if (accept) begin
         history_ff <= history_in;
         state_ff   <= state_in;
         settled_ff <= settled_in;
         count_ff   <= count_in;
         flags_ff   <= flags_in;
      end
   end

   a_count_only_pressed: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (state_ff == ST_PRESSED))
      else $error("hold count nonzero outside pressed state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(flags_ff.pressed && flags_ff.released))
      else $error("pressed and released flags both set");

   a_release_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (state_ff == ST_RELEASED)) |=> (!flags_ff.short_hold && !flags_ff.long_hold))
      else $error("hold flags survived released state");

endmodule

FILE: sv/bdlp_merge.sv
// Merge stage: gathers lane flags into result vectors and buffers them
// in an output register plus skid register. Depends on bdlp_pkg.
module bdlp_merge #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  bdlp_pkg::flags_type    lane_flags [NUM_BUTTONS],
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [NUM_BUTTONS-1:0] out_pressed,
   output logic [NUM_BUTTONS-1:0] out_short_hold,
   output logic [NUM_BUTTONS-1:0] out_long_hold,
   output logic [NUM_BUTTONS-1:0] out_released
);
   import bdlp_pkg::*;

   localparam int BEAT_W = NUM_FLAGS * NUM_BUTTONS;

   logic [NUM_BUTTONS-1:0] pf, sf, lf, rf;
   logic [BEAT_W-1:0]      beat_in;
   logic [BEAT_W-1:0]      main_ff, main_in, skid_ff, skid_in;
   logic                   main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic                   accept, take;

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         pf[i] = lane_flags[i].pressed;
         sf[i] = lane_flags[i].short_hold;
         lf[i] = lane_flags[i].long_hold;
         rf[i] = lane_flags[i].released;
      end
   end

   assign beat_in  = {pf, sf, lf, rf};
   assign in_stall = skid_valid_ff;
   assign accept   = in_valid && !skid_valid_ff;
   assign take     = main_valid_ff && !out_stall;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || take) begin
            main_in       = beat_in;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = beat_in;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid      = main_valid_ff;
   assign out_pressed    = main_ff[4*NUM_BUTTONS-1:3*NUM_BUTTONS];
   assign out_short_hold = main_ff[3*NUM_BUTTONS-1:2*NUM_BUTTONS];
   assign out_long_hold  = main_ff[2*NUM_BUTTONS-1:NUM_BUTTONS];
   assign out_released   = main_ff[NUM_BUTTONS-1:0];

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid beat held with empty output register");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && out_stall && in_valid))
      else $error("skid filled without a stalled output beat");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> !skid_valid_ff)
      else $error("skid beat not moved on output take");

endmodule

FILE: sv/button_debounce_long_press_core.sv
// Top level of the button debouncer with long-press detection.
// Depends on bdlp_pkg, bdlp_lane and bdlp_merge.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    req_pin_levels
//   rsp      out        rsp_valid/stall    rsp_pressed/short_hold/long_hold/released_flags
//   csr      in         csr_we             csr_index, csr_wdata
//
// One beat per cycle in unless req_stall is high; the merge stage registers each result.
// All lanes update in the cycle the beat is taken; the merge stage holds
// two result beats, so req_stall rises only when both are full.
// Synchronous active-high reset clears lane state and config to defaults.
module button_debounce_long_press_core #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [NUM_BUTTONS-1:0]           req_pin_levels,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [NUM_BUTTONS-1:0]           rsp_pressed_flags,
   output logic [NUM_BUTTONS-1:0]           rsp_short_hold_flags,
   output logic [NUM_BUTTONS-1:0]           rsp_long_hold_flags,
   output logic [NUM_BUTTONS-1:0]           rsp_released_flags,
   input  logic                             csr_we,
   input  logic [bdlp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bdlp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   flags_type lane_flags [NUM_BUTTONS];
   logic      accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRESSED_LEVEL: cfg_in.pressed_level    = csr_wdata[0];
            CSR_SHORT_HOLD:    cfg_in.short_hold_ticks = csr_wdata[HOLD_W-1:0];
            CSR_LONG_HOLD:     cfg_in.long_hold_ticks  = csr_wdata[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level    <= 1'b0;
         cfg_ff.short_hold_ticks <= SHORT_HOLD_RESET;
         cfg_ff.long_hold_ticks  <= LONG_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      bdlp_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .pin_level  (req_pin_levels[g]),
         .cfg        (cfg_ff),
         .flags_next (lane_flags[g])
      );
   end

   bdlp_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_stall       (req_stall),
      .lane_flags     (lane_flags),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_pressed    (rsp_pressed_flags),
      .out_short_hold (rsp_short_hold_flags),
      .out_long_hold  (rsp_long_hold_flags),
      .out_released   (rsp_released_flags)
   );

endmodule

FILE: bench/button_debounce_long_press_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for button_debounce_long_press_core: directed table, then random
// press/release runs with bounce, under several threshold settings. Needs bdlp_pkg and the RTL.
module button_debounce_long_press_core_test;
   import bdlp_pkg::*;

   localparam int NB          = NUM_BUTTONS_DEFAULT;
   localparam int NUM_PHASES  = 7;
   localparam int DRAIN_LIMIT = 5000;
   localparam int RUN_CAP_MAX = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [NB-1:0] pressed;
      logic [NB-1:0] short_hold;
      logic [NB-1:0] long_hold;
      logic [NB-1:0] released;
   } rsp_beat_type;

   typedef struct packed {
      logic [NB-1:0] pins;
      logic          typed;
      rsp_beat_type  want;
   } dir_row_type;

   localparam int DIR_ROWS_N = 24;
   localparam dir_row_type DIR_ROWS [0:DIR_ROWS_N-1] = '{
      '{3'd7, 1'b1, 12'h000}, '{3'd0, 1'b1, 12'h000}, '{3'd0, 1'b1, 12'h000},
      '{3'd0, 1'b1, 12'h000}, '{3'd0, 1'b1, 12'h000}, '{3'd0, 1'b1, 12'hE00},
      '{3'd0, 1'b1, 12'hE00}, '{3'd7, 1'b0, 12'h000}, '{3'd7, 1'b0, 12'h000},
      '{3'd7, 1'b0, 12'h000}, '{3'd7, 1'b0, 12'h000}, '{3'd5, 1'b0, 12'h000},
      '{3'd2, 1'b0, 12'h000}, '{3'd5, 1'b0, 12'h000}, '{3'd1, 1'b0, 12'h000},
      '{3'd4, 1'b0, 12'h000}, '{3'd0, 1'b0, 12'h000}, '{3'd0, 1'b0, 12'h000},
      '{3'd0, 1'b0, 12'h000}, '{3'd6, 1'b0, 12'h000}, '{3'd3, 1'b0, 12'h000},
      '{3'd7, 1'b0, 12'h000}, '{3'd7, 1'b0, 12'h000}, '{3'd7, 1'b0, 12'h000}
   };

   localparam logic              PH_LEVEL [0:NUM_PHASES-1] =
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam logic [HOLD_W-1:0] PH_SHORT [0:NUM_PHASES-1] =
      '{16'd1, 16'd3, 16'd0, 16'd5, 16'd100, 16'd65535, 16'd65534};
   localparam logic [HOLD_W-1:0] PH_LONG  [0:NUM_PHASES-1] =
      '{16'd1, 16'd8, 16'd0, 16'd2, 16'd300, 16'd65535, 16'd65535};
   localparam int PH_BEATS [0:NUM_PHASES-1] = '{120, 120, 110, 120, 256, 100, 100};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [NB-1:0]         req_pin_levels;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [NB-1:0]         rsp_pressed_flags;
   logic [NB-1:0]         rsp_short_hold_flags;
   logic [NB-1:0]         rsp_long_hold_flags;
   logic [NB-1:0]         rsp_released_flags;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   button_debounce_long_press_core #(.NUM_BUTTONS(NB)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pin_levels       (req_pin_levels),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pressed_flags    (rsp_pressed_flags),
      .rsp_short_hold_flags (rsp_short_hold_flags),
      .rsp_long_hold_flags  (rsp_long_hold_flags),
      .rsp_released_flags   (rsp_released_flags),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #10 clock = ~clock;

   // debouncer model state
   cfg_type           deb_cfg;
   logic [HIST_W-1:0] deb_hist  [NB];
   state_type         deb_state [NB];
   logic              deb_level [NB];
   logic [HOLD_W-1:0] deb_hold  [NB];
   flags_type         deb_flags [NB];

   rsp_beat_type flags_due [$];
   int unsigned  errors;
   int unsigned  beats_sent;
   int unsigned  results_seen;
   bit           calm;
   int unsigned  stall_left;

   // random press pattern state
   logic        run_level  [NB];
   int unsigned run_left   [NB];
   int unsigned bounce_left[NB];

   task automatic reset_debouncers();
      deb_cfg.pressed_level    = 1'b0;
      deb_cfg.short_hold_ticks = SHORT_HOLD_RESET;
      deb_cfg.long_hold_ticks  = LONG_HOLD_RESET;
      for (int b = 0; b < NB; b++) begin
         deb_hist[b]  = HIST_RESET;
         deb_state[b] = ST_INIT;
         deb_level[b] = 1'b0;
         deb_hold[b]  = '0;
         deb_flags[b] = '0;
      end
   endtask

   function automatic rsp_beat_type advance_debouncers(input logic [NB-1:0] pins);
      rsp_beat_type      r;
      logic [HIST_W-1:0] h;
      logic              agree;
      r = '0;
      for (int b = 0; b < NB; b++) begin
         h = {deb_hist[b][HIST_W-2:0], pins[b]};
         agree = (h == HIST_ALL_LOW) || (h == HIST_ALL_HIGH);
         deb_hist[b] = h;
         case (deb_state[b])
            ST_INIT, ST_BOUNCE_REL: begin
               if (agree) begin
                  deb_level[b] = h[0];
                  deb_state[b] = ST_STABLE;
               end
            end
            ST_STABLE: begin
               if (deb_level[b] == deb_cfg.pressed_level) deb_state[b] = ST_PRESSED;
               if (!agree) deb_state[b] = ST_BOUNCE_REL;
            end
            ST_PRESSED: begin
               deb_flags[b].released = 1'b0;
               deb_flags[b].pressed  = 1'b1;
               if (agree && deb_hold[b] != HOLD_MAX) deb_hold[b] = deb_hold[b] + 1'b1;
               if (deb_hold[b] >= deb_cfg.short_hold_ticks) deb_flags[b].short_hold = 1'b1;
               if (deb_hold[b] >= deb_cfg.long_hold_ticks) deb_flags[b].long_hold = 1'b1;
               if (!agree) begin
                  deb_state[b] = ST_BOUNCE_PRESS;
                  deb_hold[b]  = '0;
               end
            end
            ST_BOUNCE_PRESS: begin
               // settles to released whatever level it lands on
               if (agree) begin
                  deb_level[b] = h[0];
                  deb_state[b] = ST_RELEASED;
               end
            end
            ST_RELEASED: begin
               deb_flags[b] = '0;
               deb_flags[b].released = 1'b1;
               if (!agree) deb_state[b] = ST_BOUNCE_REL;
            end
            default: ;
         endcase
         r.pressed[b]    = deb_flags[b].pressed;
         r.short_hold[b] = deb_flags[b].short_hold;
         r.long_hold[b]  = deb_flags[b].long_hold;
         r.released[b]   = deb_flags[b].released;
      end
      return r;
   endfunction

   // held levels with bounce at the edges, plus some pure noise
   function automatic logic [NB-1:0] next_pins(input int unsigned cap);
      logic [NB-1:0] p;
      p = NB'($urandom);
      if ($urandom_range(0, 15) == 0) return p;
      for (int b = 0; b < NB; b++) begin
         if (run_left[b] == 0 && bounce_left[b] == 0) begin
            run_level[b]   = ~run_level[b];
            run_left[b]    = $urandom_range(1, cap);
            bounce_left[b] = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
         end
         if (bounce_left[b] != 0) begin
            p[b] = 1'($urandom_range(0, 1));
            bounce_left[b]--;
         end else begin
            p[b] = run_level[b];
            run_left[b]--;
         end
      end
      return p;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(input logic [NB-1:0] pins, input logic typed,
                            input rsp_beat_type want);
      rsp_beat_type pred;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_pin_levels <= pins;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = advance_debouncers(pins);
      flags_due.push_back(typed ? want : pred);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PRESSED_LEVEL: deb_cfg.pressed_level    = data[0];
         CSR_SHORT_HOLD:    deb_cfg.short_hold_ticks = data;
         CSR_LONG_HOLD:     deb_cfg.long_hold_ticks  = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      while (flags_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (flags_due.size() != 0) begin
         $display("%0t: %0d result beats never arrived", $time, flags_due.size());
         errors++;
         flags_due.delete();
      end
   endtask

   task automatic check_field(input string name, input logic [NB-1:0] want,
                              input logic [NB-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %b got %b", $time, name, want, got);
         errors++;
      end
   endtask

   rsp_beat_type got_beat, want_beat;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_beat = {rsp_pressed_flags, rsp_short_hold_flags, rsp_long_hold_flags,
                     rsp_released_flags};
         results_seen++;
         if (flags_due.size() == 0) begin
            $display("%0t: result beat with none pending, expected nothing got %h",
                     $time, got_beat);
            errors++;
         end else begin
            want_beat = flags_due.pop_front();
            check_field("pressed_flags", want_beat.pressed, got_beat.pressed);
            check_field("short_hold_flags", want_beat.short_hold, got_beat.short_hold);
            check_field("long_hold_flags", want_beat.long_hold, got_beat.long_hold);
            check_field("released_flags", want_beat.released, got_beat.released);
         end
      end
   end

   initial begin
      rsp_stall  <= 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 12);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("timeout at %0t", $time);
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned       cap;
      logic [CSR_DATA_W-1:0] word;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_pin_levels <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      calm         = 1'b0;
      errors       = 0;
      beats_sent   = 0;
      results_seen = 0;
      for (int b = 0; b < NB; b++) begin
         run_level[b]   = 1'($urandom_range(0, 1));
         run_left[b]    = 0;
         bounce_left[b] = 0;
      end
      reset_debouncers();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds, known opening sequence
      for (int i = 0; i < DIR_ROWS_N; i++)
         send_beat(DIR_ROWS[i].pins, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      req_valid <= 1'b0;
      drain_results();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == NUM_PHASES - 1) calm = 1'b1;
         word = CSR_DATA_W'($urandom);
         word[0] = PH_LEVEL[ph];
         write_csr(CSR_PRESSED_LEVEL, word);
         write_csr(CSR_SHORT_HOLD, PH_SHORT[ph]);
         write_csr(CSR_LONG_HOLD, PH_LONG[ph]);
         if (ph == 1) write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
         csr_we <= 1'b0;
         cap = int'(PH_LONG[ph]) + int'(PH_LONG[ph]) / 2 + 4;
         if (cap > RUN_CAP_MAX) cap = RUN_CAP_MAX;
         repeat (PH_BEATS[ph]) send_beat(next_pins(cap), 1'b0, '0);
         req_valid <= 1'b0;
         drain_results();
      end

      repeat (4) @(negedge clock);
      $display("Sent %0d beats over %0d threshold settings, %0d results checked, %0d errors",
               beats_sent, NUM_PHASES + 1, results_seen, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
sv/bdlp_pkg.sv
sv/bdlp_lane.sv
sv/bdlp_merge.sv
sv/button_debounce_long_press_core.sv
bench/button_debounce_long_press_core_test.sv
